FILE: src/mse_pkg.sv
`timescale 1ns / 1ps
package mse_pkg;

	localparam int NUM_MOVERS  = 64;
	localparam int MOVER_W     = 6;
	localparam int ADDR_W      = (NUM_MOVERS > 1) ? $clog2(NUM_MOVERS) : 1;
	localparam int POS_W       = 28;
	localparam int DIFF_W      = POS_W + 1;
	localparam int FRAME_W     = 32;
	localparam int STEP_W      = 29;
	localparam int SUM_W       = 2 * STEP_W;
	localparam int SSUM_W      = STEP_W + 1;
	localparam int REM_W       = STEP_W + 2;
	localparam int RATIO_W     = 24;
	localparam int CNT_W       = 32;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 29;
	localparam int ITER_W      = 5;
	localparam int SQRT_STEPS  = STEP_W;
	localparam int DIV_STEPS   = RATIO_W;
	localparam int FRAC_SHIFT  = 16;

	localparam logic [RATIO_W-1:0] RATIO_MAX = {RATIO_W{1'b1}};

	localparam logic [CFG_IDX_W-1:0] REG_ENABLE    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FLOOR     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd2;

	localparam logic [STEP_W-1:0]  FLOOR_RST     = 29'd4;
	localparam logic [RATIO_W-1:0] THRESHOLD_RST = 24'd3277;

	localparam logic MODE_SQRT = 1'b0;
	localparam logic MODE_DIV  = 1'b1;

	localparam logic OP_NOTE   = 1'b0;
	localparam logic OP_REPORT = 1'b1;

	typedef struct packed {
		logic signed [POS_W-1:0] px;
		logic signed [POS_W-1:0] py;
		logic signed [POS_W-1:0] pz;
		logic [FRAME_W-1:0]      frame;
		logic                    blend;
		logic [STEP_W-1:0]       older;
		logic [STEP_W-1:0]       middle;
	} entry_t;

	typedef struct packed {
		logic start;
		logic mode;
	} unit_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_sts_t;

endpackage

FILE: src/motion_step_evenness_check_top.sv
`timescale 1ns / 1ps
// channel  | handshake             | payload
// in       | in_valid / in_stall   | op, mover, pos_x/y/z, frame_number, blended
// out      | out_valid / out_stall | judged/uneven/raw_after_blend counts, worst_ratio, *_now
// cfg      | cfg_valid / cfg_ready | cfg_index, cfg_data
// A judged note passes check, three squares, root start and 29 root steps, update, deviation,
// ratio start and 24 quotient steps, judge, output and idle; a saturated ratio skips the
// quotient steps, an unjudged consecutive note ends after update. Reports and disabled notes
// go straight to output, repeated-frame and restarting notes through check to output.
// A stalled output only holds the finishing state; a waiting result does not block accept.
// Reset clears totals and valid bits and restores config at once; no table clearing pass.
module motion_step_evenness_check_top
	import mse_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      op,
	input  logic [MOVER_W-1:0]        mover,
	input  logic signed [POS_W-1:0]   pos_x,
	input  logic signed [POS_W-1:0]   pos_y,
	input  logic signed [POS_W-1:0]   pos_z,
	input  logic [FRAME_W-1:0]        frame_number,
	input  logic                      blended,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [CNT_W-1:0]          judged_count,
	output logic [CNT_W-1:0]          uneven_count,
	output logic [CNT_W-1:0]          raw_after_blend_count,
	output logic [RATIO_W-1:0]        worst_ratio,
	output logic                      judged_now,
	output logic                      uneven_now,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [CFG_IDX_W-1:0]      cfg_index,
	input  logic [CFG_DATA_W-1:0]     cfg_data
);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_CHK  = 4'd1;
	localparam logic [3:0] ST_MUL  = 4'd2;
	localparam logic [3:0] ST_SQRT = 4'd3;
	localparam logic [3:0] ST_SQW  = 4'd4;
	localparam logic [3:0] ST_UPD  = 4'd5;
	localparam logic [3:0] ST_DEV  = 4'd6;
	localparam logic [3:0] ST_DIV  = 4'd7;
	localparam logic [3:0] ST_DVW  = 4'd8;
	localparam logic [3:0] ST_JUD  = 4'd9;
	localparam logic [3:0] ST_FIN  = 4'd10;

	logic [3:0] state_q;

	logic                    enable_q;
	logic [STEP_W-1:0]       floor_q;
	logic [RATIO_W-1:0]      thr_q;
	logic [CNT_W-1:0]        judged_q;
	logic [CNT_W-1:0]        uneven_q;
	logic [CNT_W-1:0]        rab_q;
	logic [RATIO_W-1:0]      worst_q;

	logic [NUM_MOVERS-1:0]   ev_q;
	logic [NUM_MOVERS-1:0]   ov_q;
	logic [NUM_MOVERS-1:0]   mv_q;

	logic                    op_q;
	logic [MOVER_W-1:0]      mover_q;
	logic signed [POS_W-1:0] px_q;
	logic signed [POS_W-1:0] py_q;
	logic signed [POS_W-1:0] pz_q;
	logic [FRAME_W-1:0]      frame_q;
	logic                    blend_q;
	logic                    jnow_q;
	logic                    unow_q;

	entry_t                  ent_q;
	entry_t                  rd_ent;
	entry_t                  wr_ent;
	logic [$bits(entry_t)-1:0] rd_raw;
	logic                    wr_en;
	logic [ADDR_W-1:0]       rd_addr;
	logic [ADDR_W-1:0]       addr;

	logic signed [DIFF_W-1:0] dx_q;
	logic signed [DIFF_W-1:0] dy_q;
	logic signed [DIFF_W-1:0] dz_q;
	logic signed [DIFF_W-1:0] msel;
	logic [DIFF_W-2:0]       mabs;
	logic [2*(DIFF_W-1)-1:0] msq;
	logic [1:0]              mcnt_q;
	logic [SUM_W-1:0]        prod_q;
	logic [SUM_W-1:0]        sum_q;
	logic [SSUM_W-1:0]       s_q;
	logic [SSUM_W-1:0]       dev_q;
	logic [SSUM_W-1:0]       twice;
	logic [RATIO_W-1:0]      ratio_q;

	unit_ctl_t               uctl;
	unit_sts_t               usts;
	logic [STEP_W-1:0]       ures;
	logic [SUM_W-1:0]        un;
	logic [REM_W-1:0]        urem;

	logic                    accept;
	logic                    active;
	logic                    hit;
	logic                    consec;
	logic                    judge;
	logic                    sat;
	logic                    out_free;

	assign accept    = in_valid && !in_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign addr      = mover_q[ADDR_W-1:0];
	assign rd_addr   = accept ? mover[ADDR_W-1:0] : addr;
	assign rd_ent    = entry_t'(rd_raw);
	assign out_free  = !out_valid || !out_stall;
	assign active    = enable_q && ({1'b0, mover} < (MOVER_W + 1)'(NUM_MOVERS));

	assign hit    = ev_q[addr] && (rd_ent.frame == frame_q);
	assign consec = ev_q[addr] && (FRAME_W'(rd_ent.frame + 1'b1) == frame_q);
	assign judge  = ov_q[addr] && mv_q[addr] && (ent_q.older > floor_q) &&
	                (ent_q.middle > floor_q) && (ures > floor_q);
	assign twice  = {ent_q.middle, 1'b0};
	assign sat    = {{8{1'b0}}, dev_q} >= {s_q, 8'b0};

	always_comb begin
		unique case (mcnt_q)
			2'd0:    msel = dx_q;
			2'd1:    msel = dy_q;
			default: msel = dz_q;
		endcase
	end

	// a difference never reaches the most negative value, so its magnitude fits
	assign mabs = msel[DIFF_W-1] ? (DIFF_W - 1)'(-msel) : msel[DIFF_W-2:0];
	assign msq  = mabs * mabs;

	always_comb begin
		wr_ent.px    = px_q;
		wr_ent.py    = py_q;
		wr_ent.pz    = pz_q;
		wr_ent.frame = frame_q;
		wr_ent.blend = blend_q;
		if (state_q == ST_UPD) begin
			wr_ent.older  = ent_q.middle;
			wr_ent.middle = ures;
		end else begin
			wr_ent.older  = rd_ent.older;
			wr_ent.middle = rd_ent.middle;
		end
		wr_en = (state_q == ST_UPD) || (state_q == ST_CHK && !hit && !consec);
	end

	always_comb begin
		uctl.start = (state_q == ST_SQRT) || (state_q == ST_DIV && !sat);
		uctl.mode  = (state_q == ST_SQRT) ? MODE_SQRT : MODE_DIV;
		if (state_q == ST_SQRT) begin
			un   = sum_q;
			urem = '0;
		end else begin
			un   = {(SUM_W - 8 - FRAC_SHIFT)'(0), dev_q[7:0], FRAC_SHIFT'(0)};
			urem = REM_W'(dev_q[SSUM_W-1:8]);
		end
	end

	mse_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(NUM_MOVERS)
	) u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (addr),
		.wr_data (wr_ent),
		.rd_addr (rd_addr),
		.rd_data (rd_raw)
	);

	mse_iter u_iter (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (uctl),
		.n_in   (un),
		.d_in   (s_q),
		.rem_in (urem),
		.sts    (usts),
		.result (ures)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			enable_q  <= 1'b0;
			floor_q   <= FLOOR_RST;
			thr_q     <= THRESHOLD_RST;
			judged_q  <= '0;
			uneven_q  <= '0;
			rab_q     <= '0;
			worst_q   <= '0;
			ev_q      <= '0;
			ov_q      <= '0;
			mv_q      <= '0;
			out_valid <= 1'b0;
			mcnt_q    <= '0;
		end else begin
			if (out_valid && !out_stall && state_q != ST_FIN) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (op == OP_REPORT || !active) begin
							state_q <= ST_FIN;
						end else begin
							state_q <= ST_CHK;
						end
					end
				end
				ST_CHK: begin
					mcnt_q <= '0;
					if (hit) begin
						state_q <= ST_FIN;
					end else if (consec) begin
						state_q <= ST_MUL;
					end else begin
						ev_q[addr] <= 1'b1;
						ov_q[addr] <= 1'b0;
						mv_q[addr] <= 1'b0;
						state_q    <= ST_FIN;
					end
				end
				ST_MUL: begin
					mcnt_q <= mcnt_q + 1'b1;
					if (mcnt_q == 2'd3) begin
						state_q <= ST_SQRT;
					end
				end
				ST_SQRT: state_q <= ST_SQW;
				ST_SQW: begin
					if (usts.done) begin
						state_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					ov_q[addr] <= mv_q[addr];
					mv_q[addr] <= 1'b1;
					if (!blend_q && ent_q.blend) begin
						rab_q <= rab_q + 1'b1;
					end
					state_q <= judge ? ST_DEV : ST_FIN;
				end
				ST_DEV: state_q <= ST_DIV;
				ST_DIV: state_q <= sat ? ST_JUD : ST_DVW;
				ST_DVW: begin
					if (usts.done) begin
						state_q <= ST_JUD;
					end
				end
				ST_JUD: begin
					judged_q <= judged_q + 1'b1;
					if (ratio_q > thr_q) begin
						uneven_q <= uneven_q + 1'b1;
					end
					if (ratio_q > worst_q) begin
						worst_q <= ratio_q;
					end
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free) begin
						out_valid <= 1'b1;
						state_q   <= ST_IDLE;
						if (op_q == OP_REPORT && enable_q && judged_q != '0) begin
							judged_q <= '0;
							uneven_q <= '0;
							rab_q    <= '0;
							worst_q  <= '0;
						end
					end else begin
						out_valid <= 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_ENABLE: begin
						enable_q <= cfg_data[0];
						judged_q <= '0;
						uneven_q <= '0;
						rab_q    <= '0;
						worst_q  <= '0;
					end
					REG_FLOOR:     floor_q <= cfg_data[STEP_W-1:0];
					REG_THRESHOLD: thr_q   <= cfg_data[RATIO_W-1:0];
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= op;
			mover_q <= mover;
			px_q    <= pos_x;
			py_q    <= pos_y;
			pz_q    <= pos_z;
			frame_q <= frame_number;
			blend_q <= blended;
			jnow_q  <= 1'b0;
			unow_q  <= 1'b0;
		end
		if (state_q == ST_CHK) begin
			ent_q <= rd_ent;
			dx_q  <= DIFF_W'(px_q) - DIFF_W'(rd_ent.px);
			dy_q  <= DIFF_W'(py_q) - DIFF_W'(rd_ent.py);
			dz_q  <= DIFF_W'(pz_q) - DIFF_W'(rd_ent.pz);
			sum_q <= '0;
		end
		if (state_q == ST_MUL) begin
			prod_q <= SUM_W'(msq);
			if (mcnt_q != 2'd0) begin
				sum_q <= sum_q + prod_q;
			end
		end
		if (state_q == ST_UPD) begin
			s_q <= {1'b0, ent_q.older} + {1'b0, ures};
		end
		if (state_q == ST_DEV) begin
			dev_q <= (twice > s_q) ? (twice - s_q) : (s_q - twice);
		end
		if (state_q == ST_DIV && sat) begin
			ratio_q <= RATIO_MAX;
		end
		if (state_q == ST_DVW && usts.done) begin
			ratio_q <= ures[RATIO_W-1:0];
		end
		if (state_q == ST_JUD) begin
			jnow_q <= 1'b1;
			unow_q <= (ratio_q > thr_q);
		end
		if (state_q == ST_FIN && out_free) begin
			judged_count          <= judged_q;
			uneven_count          <= uneven_q;
			raw_after_blend_count <= rab_q;
			worst_ratio           <= worst_q;
			judged_now            <= jnow_q;
			uneven_now            <= unow_q;
		end
	end

	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		usts.done |-> (state_q == ST_SQW || state_q == ST_DVW))
		else $error("iterative unit finished outside a wait state");

	a_uneven_judged: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && uneven_now) |-> judged_now)
		else $error("uneven flag without a judged frame");

	a_wr_state: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (state_q == ST_CHK || state_q == ST_UPD))
		else $error("table write outside an update state");

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		uctl.start |-> !usts.busy)
		else $error("unit started while busy");

endmodule

FILE: src/mse_ram.sv
`timescale 1ns / 1ps
module mse_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

FILE: src/mse_iter.sv
`timescale 1ns / 1ps
module mse_iter
	import mse_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  unit_ctl_t         ctl,
	input  logic [SUM_W-1:0]  n_in,
	input  logic [SSUM_W-1:0] d_in,
	input  logic [REM_W-1:0]  rem_in,
	output unit_sts_t         sts,
	output logic [STEP_W-1:0] result
);

	logic [SUM_W-1:0]  n_q;
	logic [SSUM_W-1:0] d_q;
	logic [REM_W-1:0]  rem_q;
	logic [STEP_W-1:0] res_q;
	logic [ITER_W-1:0] cnt_q;
	logic              mode_q;
	logic              busy_q;
	logic              done_q;
	logic [REM_W+1:0]  a;
	logic [REM_W+1:0]  b;
	logic [REM_W+2:0]  diff;
	logic              ge;

	always_comb begin
		if (mode_q == MODE_SQRT) begin
			a = {rem_q, n_q[SUM_W-1 -: 2]};
			b = {2'b00, res_q, 2'b01};
		end else begin
			a = {1'b0, rem_q, n_q[DIV_STEPS-1]};
			b = {(REM_W + 2 - SSUM_W)'(0), d_q};
		end
		diff = {1'b0, a} - {1'b0, b};
		ge   = !diff[REM_W+2];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= (ctl.mode == MODE_SQRT) ? ITER_W'(SQRT_STEPS - 1)
				                                  : ITER_W'(DIV_STEPS - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			mode_q <= ctl.mode;
			n_q    <= n_in;
			d_q    <= d_in;
			rem_q  <= rem_in;
			res_q  <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[REM_W-1:0] : a[REM_W-1:0];
			res_q <= {res_q[STEP_W-2:0], ge};
			if (mode_q == MODE_SQRT) begin
				n_q <= {n_q[SUM_W-3:0], 2'b00};
			end else begin
				n_q <= {n_q[SUM_W-2:0], 1'b0};
			end
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign result   = res_q;

endmodule
